// ===== rtl/lcg_entropy_bit_pool_defines.svh =====
// Assertion macros shared by the bit pool RTL.
`ifndef LCG_ENTROPY_BIT_POOL_DEFINES_SVH
`define LCG_ENTROPY_BIT_POOL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LEP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LEP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lep_pkg.sv =====
// Types and constants of the LCG entropy bit pool.
package lep_pkg;

  typedef enum logic [1:0] {
    ACT_DRAW   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_RAND   = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DRAW = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_PUSH = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    MOP_REFILL_A = 2'd0,
    MOP_REFILL_B = 2'd1,
    MOP_CLASSIC  = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
    logic [63:0] factor;
    logic [63:0] addend;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  localparam logic [63:0] REFILL_MUL_A = 64'd110356915245;
  localparam logic [63:0] REFILL_INC_A = 64'd12345;
  localparam logic [63:0] REFILL_MUL_B = 64'd69420;
  localparam logic [63:0] CLASSIC_MUL  = 64'd1103515245;
  localparam logic [63:0] CLASSIC_INC  = 64'd12345;

  localparam logic [6:0] MAX_DRAW   = 7'd30;
  localparam logic [6:0] MAX_INSERT = 7'd64;

endpackage

// ===== rtl/lep_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lep_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lep_seed_mul.sv =====
// Multi-cycle 64-bit multiply-add unit for seed updates, 16 factor bits per cycle.
module lep_seed_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  lep_pkg::mul_req_t req,
  output lep_pkg::mul_rsp_t rsp
);

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] k_r, k_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [79:0] pp;

  assign pp = {16'b0, a_r} * {64'b0, k_r[15:0]};

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    k_nxt    = k_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = req.addend;
      a_nxt    = req.operand;
      k_nxt    = req.factor;
      step_nxt = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt  = acc_r + pp[63:0];
      a_nxt    = {a_r[47:0], 16'b0};
      k_nxt    = {16'b0, k_r[63:16]};
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    k_r   <= k_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

// ===== rtl/lcg_entropy_bit_pool.sv =====
// LCG entropy bit pool: a 64-bit seed feeding a last-in-first-out bit stack in RAM.
//
// Requests arrive on the in_ channel (valid/ready) and each produces exactly one
// response on the out_ channel (valid/ready), in order. Actions:
//   draw   - pop 0 to 30 bits (more saturates to 30), first popped bit is the MSB;
//            an empty stack is refilled from the seed with REFILL_BITS bits.
//   insert - push up to 64 bits of in_insert_value, LSB first; bits arriving
//            while the stack is full are dropped.
//   flush  - empty the stack.
//   rand   - one classic LCG step; returns seed bits 30..16.
// Timing: one request at a time. A draw pops one stack bit per cycle through the RAM
// read port, paused while an empty stack is refilled; a refill runs two multiply
// passes, then pushes one bit per cycle and resumes the draw. The response sits in
// an output register; a new request is accepted while it waits, but the next
// response holds until out_ready takes the previous one.
// Reset (rst_n low, synchronous) empties the stack and sets the seed to one; the
// RAM contents are not cleared and need no clearing pass.
`include "lcg_entropy_bit_pool_defines.svh"

module lcg_entropy_bit_pool #(
  parameter int POOL_BITS   = 16384,
  parameter int REFILL_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [6:0]  in_bit_count,
  input  logic [63:0] in_insert_value,
  input  logic [31:0] in_time_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_result_value,
  output logic [14:0] out_bits_stored
);

  localparam int FW = $clog2(POOL_BITS + 1);
  localparam int AW = $clog2(POOL_BITS);
  localparam logic [FW-1:0] POOL_MAX = FW'(POOL_BITS);
  localparam logic [6:0] REFILL_CNT = 7'(REFILL_BITS);

  lep_pkg::state_t  state_r, state_nxt;
  lep_pkg::mul_op_t mop_r, mop_nxt;
  lep_pkg::mul_req_t mul_req;
  lep_pkg::mul_rsp_t mul_rsp;

  logic [FW-1:0] fill_r, fill_nxt;
  logic [63:0]   seed_r, seed_nxt;
  logic [4:0]    rem_r, rem_nxt;
  logic [63:0]   push_val_r, push_val_nxt;
  logic [6:0]    push_left_r, push_left_nxt;
  logic          push_draw_r, push_draw_nxt;
  logic [31:0]   time_r, time_nxt;
  logic [29:0]   res_r, res_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [30:0]   out_result_value_r, out_result_value_nxt;
  logic [14:0]   out_bits_stored_r, out_bits_stored_nxt;

  logic          pop_en;
  logic          push_en;
  logic [FW-1:0] fill_dec;
  logic [AW-1:0] ram_raddr;
  logic [AW-1:0] ram_waddr;
  logic          ram_rdata;
  logic [63:0]   time_mix;
  logic [FW+14:0] fill_ext;

  assign fill_dec  = fill_r - 1'b1;
  assign ram_raddr = fill_dec[AW-1:0];
  assign ram_waddr = fill_r[AW-1:0];
  assign time_mix  = {28'b0, time_r, 4'b0} + {29'b0, time_r, 3'b0};
  assign fill_ext  = {15'b0, fill_r};

  lep_ram #(
    .WIDTH (1),
    .DEPTH (POOL_BITS)
  ) u_store (
    .clk   (clk),
    .we    (push_en),
    .waddr (ram_waddr),
    .wdata (push_val_r[0]),
    .re    (pop_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lep_seed_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_comb begin
    state_nxt            = state_r;
    mop_nxt              = mop_r;
    fill_nxt             = fill_r;
    seed_nxt             = seed_r;
    rem_nxt              = rem_r;
    push_val_nxt         = push_val_r;
    push_left_nxt        = push_left_r;
    push_draw_nxt        = push_draw_r;
    time_nxt             = time_r;
    res_nxt              = res_r;
    rd_pend_nxt          = 1'b0;
    out_valid_nxt        = out_valid_r & ~out_ready;
    out_result_value_nxt = out_result_value_r;
    out_bits_stored_nxt  = out_bits_stored_r;
    pop_en               = 1'b0;
    push_en              = 1'b0;
    mul_req.start        = 1'b0;
    mul_req.operand      = seed_r;
    mul_req.factor       = lep_pkg::REFILL_MUL_A;
    mul_req.addend       = lep_pkg::REFILL_INC_A;

    if (rd_pend_r) begin
      res_nxt = {res_r[28:0], ram_rdata};
    end

    case (state_r)
      lep_pkg::ST_IDLE: begin
        if (in_valid) begin
          time_nxt = in_time_now;
          res_nxt  = '0;
          case (lep_pkg::action_t'(in_action))
            lep_pkg::ACT_DRAW: begin
              rem_nxt   = (in_bit_count > lep_pkg::MAX_DRAW) ? lep_pkg::MAX_DRAW[4:0]
                                                             : in_bit_count[4:0];
              state_nxt = lep_pkg::ST_DRAW;
            end
            lep_pkg::ACT_INSERT: begin
              push_val_nxt  = in_insert_value;
              push_left_nxt = (in_bit_count > lep_pkg::MAX_INSERT) ? lep_pkg::MAX_INSERT
                                                                   : in_bit_count;
              push_draw_nxt = 1'b0;
              state_nxt     = lep_pkg::ST_PUSH;
            end
            lep_pkg::ACT_FLUSH: begin
              fill_nxt  = '0;
              state_nxt = lep_pkg::ST_RESP;
            end
            default: begin
              mul_req.start  = 1'b1;
              mul_req.factor = lep_pkg::CLASSIC_MUL;
              mul_req.addend = lep_pkg::CLASSIC_INC;
              mop_nxt        = lep_pkg::MOP_CLASSIC;
              state_nxt      = lep_pkg::ST_MUL;
            end
          endcase
        end
      end
      lep_pkg::ST_DRAW: begin
        if (rem_r != '0) begin
          if (fill_r != '0) begin
            pop_en      = 1'b1;
            fill_nxt    = fill_dec;
            rem_nxt     = rem_r - 5'd1;
            rd_pend_nxt = 1'b1;
          end else begin
            mul_req.start = 1'b1;
            mop_nxt       = lep_pkg::MOP_REFILL_A;
            state_nxt     = lep_pkg::ST_MUL;
          end
        end else if (!rd_pend_r) begin
          state_nxt = lep_pkg::ST_RESP;
        end
      end
      lep_pkg::ST_MUL: begin
        if (mul_rsp.done) begin
          case (mop_r)
            lep_pkg::MOP_REFILL_A: begin
              mul_req.start   = 1'b1;
              mul_req.operand = mul_rsp.product;
              mul_req.factor  = lep_pkg::REFILL_MUL_B;
              mul_req.addend  = time_mix;
              mop_nxt         = lep_pkg::MOP_REFILL_B;
            end
            lep_pkg::MOP_REFILL_B: begin
              seed_nxt      = mul_rsp.product;
              push_val_nxt  = mul_rsp.product;
              push_left_nxt = REFILL_CNT;
              push_draw_nxt = 1'b1;
              state_nxt     = lep_pkg::ST_PUSH;
            end
            default: begin
              seed_nxt  = mul_rsp.product;
              res_nxt   = {15'b0, mul_rsp.product[30:16]};
              state_nxt = lep_pkg::ST_RESP;
            end
          endcase
        end
      end
      lep_pkg::ST_PUSH: begin
        if (push_left_r == '0) begin
          state_nxt = push_draw_r ? lep_pkg::ST_DRAW : lep_pkg::ST_RESP;
        end else begin
          if (fill_r < POOL_MAX) begin
            push_en  = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
          push_val_nxt  = {1'b0, push_val_r[63:1]};
          push_left_nxt = push_left_r - 7'd1;
        end
      end
      lep_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_result_value_nxt = {1'b0, res_r};
          out_bits_stored_nxt  = fill_ext[14:0];
          state_nxt            = lep_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lep_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lep_pkg::ST_IDLE;
      mop_r       <= lep_pkg::MOP_CLASSIC;
      fill_r      <= '0;
      seed_r      <= 64'd1;
      rem_r       <= '0;
      push_left_r <= '0;
      push_draw_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mop_r       <= mop_nxt;
      fill_r      <= fill_nxt;
      seed_r      <= seed_nxt;
      rem_r       <= rem_nxt;
      push_left_r <= push_left_nxt;
      push_draw_r <= push_draw_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    push_val_r         <= push_val_nxt;
    time_r             <= time_nxt;
    res_r              <= res_nxt;
    out_result_value_r <= out_result_value_nxt;
    out_bits_stored_r  <= out_bits_stored_nxt;
  end

  assign in_ready         = (state_r == lep_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;
  assign out_bits_stored  = out_bits_stored_r;

  `LEP_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= POOL_MAX, "stack fill above pool size")
  `LEP_ASSERT_IMP(a_pop_nonempty, pop_en, fill_r != '0, "pop from an empty stack")
  `LEP_ASSERT_NXT(a_pop_collect, pop_en, rd_pend_r, "popped bit not collected")
  `LEP_ASSERT_IMP(a_idle_clean, state_r == lep_pkg::ST_IDLE, !rd_pend_r, "read pending in idle")
  `LEP_ASSERT_IMP(a_mul_owner, mul_rsp.done, state_r == lep_pkg::ST_MUL, "stray multiply done")

endmodule
